[hdl/cft_pkg.sv]
// Package for the cycloid foot trajectory block: sequencer states, codes, sine ROM, helpers.
`timescale 1ns / 1ps
package cft_pkg;

  // Phase format and sine table geometry
  localparam int PhBits    = 16;
  localparam int RomDepth  = 256;
  localparam int RomAw     = $clog2(RomDepth);
  localparam int RotBits   = $clog2(4 * RomDepth);
  localparam int FracShift = PhBits - RotBits;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_LEG_PAIR     = 3'd0;
  localparam logic [2:0] CFG_SIDE_STROKE  = 3'd1;
  localparam logic [2:0] CFG_BASE_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_LIFT_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_SIDE_OFFSET  = 3'd4;
  localparam logic [2:0] CFG_STANCE_SPEED = 3'd5;
  localparam logic [2:0] CFG_TIME_SCALE   = 3'd6;
  localparam logic [2:0] CFG_TICK_PERIOD  = 3'd7;

  // Leg pair codes
  localparam logic [1:0] PAIR_FIRST  = 2'd1;
  localparam logic [1:0] PAIR_SECOND = 2'd2;

  // 1/(2*pi) in Q30 and pi/2 in Q30
  localparam logic signed [32:0] INV_2PI_Q30 = 33'sd170891319;
  localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0]        Q30_ONE     = 64'd1073741824;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_INTERP,
    ST_CYCMUL,
    ST_CYC,
    ST_PMUL,
    ST_POST,
    ST_SMUL1,
    ST_SMUL2,
    ST_DINIT,
    ST_DIV,
    ST_SFIN,
    ST_DONE
  } state_e;

  typedef logic [16:0] sine_rom_t [0:RomDepth];

  // Quarter-wave table, Q16, built from a truncated sine series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    for (int i = 0; i <= RomDepth; i++) begin
      x   = (PI_HALF_Q30 * 64'(i)) / 64'(RomDepth);
      x2  = (x * x) >> 30;
      acc = Q30_ONE;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd210;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd156;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd110;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd72;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd42;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd20;
      acc = Q30_ONE - ((x2 * acc) >> 30) / 64'd6;
      rom[i] = 17'((((x * acc) >> 30) + 64'd8192) >> 14);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Full-wave sample k, 4*RomDepth samples per turn
  function automatic logic signed [17:0] sine_full(input logic [RotBits:0] k);
    logic [1:0]           quad;
    logic [RomAw-1:0]     r;
    logic [RomAw:0]       idx;
    logic signed [17:0]   v;
    quad = k[RotBits-1 -: 2];
    r    = k[RomAw-1:0];
    idx  = quad[0] ? ((RomAw+1)'(RomDepth) - {1'b0, r}) : {1'b0, r};
    v    = signed'({1'b0, SINE_ROM[idx]});
    return quad[1] ? -v : v;
  endfunction

  // Arithmetic shift right that rounds toward zero
  function automatic logic signed [65:0] shr_tz(input logic signed [65:0] x,
                                                input int n);
    logic signed [65:0] bias;
    bias = x[65] ? ((66'sd1 <<< n) - 66'sd1) : 66'sd0;
    return (x + bias) >>> n;
  endfunction

  // Clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/cycloid_foot_trajectory.sv]
// Cycloid foot trajectory generator: sequencer around one shared multiplier and a divider step.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries a phase word, unsigned Q1.16.
//  Output channel (out_valid_o / out_stall_i) carries the sideways and vertical
//  coordinates, signed Q16.16. Every input word gives exactly one output word.
//  Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//  while the block is idle; they take effect for the next word.
//  A word that holds (phase above one, or leg pair 0/3) goes straight to done;
//  a swing word takes two passes of the sine/cycloid sequence on the shared
//  multiplier; a stance word runs the 31-step restoring divider unless the
//  quotient is zero or overflows. Only one word is in flight: in_stall_o is high
//  from acceptance until the result has been moved into the output register.
//  The output register holds the last coordinates; when the receiver stalls,
//  the finished result waits in the sequencer until the output register frees.
//  Reset clears the held coordinates to zero, leg pair to 1, time constant and
//  tick period to 1.0, the other registers to zero, and empties both channels.
module cycloid_foot_trajectory (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [16:0] phase_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] side_coord_o,
  output logic [31:0] vert_coord_o
);
  import cft_pkg::*;

  // Configuration registers
  logic [1:0]         leg_pair_q;
  logic signed [31:0] side_stroke_q, base_height_q, lift_height_q;
  logic signed [31:0] side_offset_q, stance_speed_q;
  logic [30:0]        time_scale_q, tick_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_pair_q     <= PAIR_FIRST;
      side_stroke_q  <= '0;
      base_height_q  <= '0;
      lift_height_q  <= '0;
      side_offset_q  <= '0;
      stance_speed_q <= '0;
      time_scale_q   <= 31'd65536;
      tick_period_q  <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEG_PAIR:     leg_pair_q     <= cfg_wdata_i[1:0];
        CFG_SIDE_STROKE:  side_stroke_q  <= cfg_wdata_i;
        CFG_BASE_HEIGHT:  base_height_q  <= cfg_wdata_i;
        CFG_LIFT_HEIGHT:  lift_height_q  <= cfg_wdata_i;
        CFG_SIDE_OFFSET:  side_offset_q  <= cfg_wdata_i;
        CFG_STANCE_SPEED: stance_speed_q <= cfg_wdata_i;
        CFG_TIME_SCALE:   time_scale_q   <= cfg_wdata_i[30:0];
        CFG_TICK_PERIOD:  tick_period_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  // Datapath registers
  logic [16:0]        arg_q, s_q;
  logic [15:0]        stq_q;
  logic               vert_pass_q;
  logic signed [17:0] a_q, b_q;
  logic [15:0]        frac_q;
  logic signed [65:0] prod_q;
  logic signed [32:0] c_q;
  logic [62:0]        rem_q;
  logic [60:0]        dv_q;
  logic [30:0]        quo_q;
  logic [4:0]         cnt_q;
  logic [31:0]        res_side_q, res_vert_q;
  logic [31:0]        held_side_q, held_vert_q;
  logic               out_valid_q;

  // Input decode
  logic        accept;
  logic        hold_word;
  logic        swing_word;
  logic [16:0] local_ph;
  logic [15:0] stance_q;
  logic [18:0] four_local;
  logic [16:0] s_arg;

  always_comb begin
    accept     = in_valid_i && !in_stall_o;
    hold_word  = (phase_i > 17'd65536) ||
                 ((leg_pair_q != PAIR_FIRST) && (leg_pair_q != PAIR_SECOND));
    swing_word = (leg_pair_q == PAIR_FIRST) ? (phase_i <= 17'd32768)
                                             : (phase_i >= 17'd32768);
    local_ph   = (leg_pair_q == PAIR_FIRST) ? phase_i : (phase_i - 17'd32768);
    stance_q   = (leg_pair_q == PAIR_FIRST) ? 16'(phase_i - 17'd32768)
                                             : phase_i[15:0];
    four_local = {local_ph, 2'b00};
    s_arg      = (local_ph <= 17'd16384) ? four_local[16:0]
                                          : 17'(19'd131072 - four_local);
  end

  // Shared multiplier operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [18:0] diff;
  logic signed [65:0] tr16, tr30;
  logic signed [32:0] sine_v;
  logic signed [32:0] t30;
  logic signed [34:0] m_wide;
  logic signed [32:0] spd33, mag;

  always_comb begin
    diff   = 19'(b_q) - 19'(a_q);
    tr16   = shr_tz(prod_q, 16);
    tr30   = shr_tz(prod_q, 30);
    sine_v = 33'(a_q) + tr16[32:0];
    t30    = signed'({2'b00, arg_q, 14'b0});
    m_wide = 35'(c_q) * 35'sd2 - 35'(t30) - 35'sd536870912;
    spd33  = 33'(stance_speed_q);
    mag    = spd33[32] ? -spd33 : spd33;
    unique case (state_q)
      ST_INTERP: begin
        mul_a = 33'(diff);
        mul_b = signed'({17'b0, frac_q});
      end
      ST_CYCMUL: begin
        mul_a = sine_v;
        mul_b = INV_2PI_Q30;
      end
      ST_PMUL: begin
        mul_a = vert_pass_q ? 33'(lift_height_q) : 33'(side_stroke_q);
        mul_b = vert_pass_q ? c_q : m_wide[32:0];
      end
      ST_SMUL1: begin
        mul_a = mag;
        mul_b = signed'({17'b0, stq_q});
      end
      ST_SMUL2: begin
        mul_a = signed'({1'b0, prod_q[47:16]});
        mul_b = signed'({1'b0, tick_period_q, 1'b0});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Divider step and stance result
  logic               div_ge;
  logic               num_zero, num_ovf;
  logic signed [65:0] term, stance_side;

  always_comb begin
    div_ge      = rem_q >= {2'b00, dv_q};
    num_zero    = (prod_q[62:0] == '0);
    num_ovf     = prod_q[62:0] >= {1'b0, time_scale_q, 31'b0};
    term        = spd33[32] ? -signed'({35'b0, quo_q}) : signed'({35'b0, quo_q});
    stance_side = shr_tz(66'(side_stroke_q), 1) - term - 66'(side_offset_q);
  end

  // Control outputs
  logic load_res;
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    load_res    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    out_valid_o = out_valid_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (hold_word) state_d = ST_DONE;
          else if (swing_word)    state_d = ST_LOOK;
          else                    state_d = ST_SMUL1;
        end
      end
      ST_LOOK:   state_d = ST_INTERP;
      ST_INTERP: state_d = ST_CYCMUL;
      ST_CYCMUL: state_d = ST_CYC;
      ST_CYC:    state_d = ST_PMUL;
      ST_PMUL:   state_d = ST_POST;
      ST_POST:   state_d = vert_pass_q ? ST_DONE : ST_LOOK;
      ST_SMUL1:  state_d = ST_SMUL2;
      ST_SMUL2:  state_d = ST_DINIT;
      ST_DINIT:  state_d = (num_zero || num_ovf) ? ST_SFIN : ST_DIV;
      ST_DIV:    state_d = (cnt_q == 5'd0) ? ST_SFIN : ST_DIV;
      ST_SFIN:   state_d = ST_DONE;
      ST_DONE:   state_d = load_res ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_side_q <= '0;
      held_vert_q <= '0;
      vert_pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
        held_side_q <= res_side_q;
        held_vert_q <= res_vert_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE) begin
        vert_pass_q <= 1'b0;
      end else if (state_q == ST_POST) begin
        vert_pass_q <= 1'b1;
      end
    end
  end

  // Datapath, sequenced by state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          arg_q      <= {local_ph[15:0], 1'b0};
          s_q        <= s_arg;
          stq_q      <= stance_q;
          res_side_q <= held_side_q;
          res_vert_q <= held_vert_q;
        end
      end
      ST_LOOK: begin
        a_q    <= sine_full(arg_q[PhBits:FracShift]);
        b_q    <= sine_full(arg_q[PhBits:FracShift] + 11'd1);
        frac_q <= {arg_q[FracShift-1:0], RotBits'(0)};
      end
      ST_INTERP, ST_CYCMUL, ST_PMUL, ST_SMUL1, ST_SMUL2: prod_q <= mul_p;
      ST_CYC: c_q <= t30 - tr16[32:0];
      ST_POST: begin
        if (vert_pass_q) begin
          res_vert_q <= sat32(66'(base_height_q) - tr30);
        end else begin
          res_side_q <= sat32(tr30 - 66'(side_offset_q));
          arg_q      <= s_q;
        end
      end
      ST_DINIT: begin
        rem_q <= prod_q[62:0];
        dv_q  <= {time_scale_q, 30'b0};
        cnt_q <= 5'd30;
        quo_q <= num_zero ? '0 : (num_ovf ? '1 : '0);
      end
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - {2'b00, dv_q};
        quo_q <= {quo_q[29:0], div_ge};
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      ST_SFIN: begin
        res_side_q <= sat32(stance_side);
        res_vert_q <= base_height_q;
      end
      default: ;
    endcase
  end

  assign side_coord_o = held_side_q;
  assign vert_coord_o = held_vert_q;

`ifndef ASSERT_OFF
  // An accepted word always makes the sequencer busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("sequencer idle after accepting a word");

  // Divider count stays within its 31 steps
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= 5'd30))
    else $error("divider count out of range");

  // Loading a result leaves a valid word on the output
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("result load did not present a word");
`endif

endmodule

[tb/cycloid_foot_trajectory_test.sv]
// Testbench for the cycloid foot trajectory generator: directed and random phases, self-checked.
`timescale 1ns / 1ps
module cycloid_foot_trajectory_test;
  import cft_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_LEG_PAIR;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [16:0] phase_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] side_coord_o;
  logic [31:0] vert_coord_o;

  cycloid_foot_trajectory u_top (.*);

  always #4 clk_i = ~clk_i;

  // Shadow of the register file and held coordinates
  logic [1:0]  pair_q;
  logic [31:0] stroke_q, base_q, lift_q, offset_q, speed_q;
  logic [30:0] tscale_q, tick_q;
  logic [31:0] held_side_q, held_vert_q;
  longint      quarter_sine [0:256];

  logic [63:0] coord_queue [$];
  int          mismatches = 0;
  bit          quiet = 1'b0;     // no idling on either side
  int          long_hold = 0;    // length of the long hold-off, set by the test
  bit          long_taken = 1'b0;
  int          hold_cycles = 0;  // cycles left in the current receiver hold-off

  // Quarter-wave table, same integer series as the ROM
  task automatic fill_sine_table();
    longint unsigned x, x2, acc;
    longint unsigned divs [7] = '{210, 156, 110, 72, 42, 20, 6};
    for (int i = 0; i <= 256; i++) begin
      x   = 64'd1686629713 * i / 256;
      x2  = (x * x) >> 30;
      acc = 64'd1 << 30;
      for (int n = 0; n < 7; n++) acc = (64'd1 << 30) - ((x2 * acc) >> 30) / divs[n];
      quarter_sine[i] = longint'((((x * acc) >> 30) + 8192) >> 14);
    end
  endtask

  function automatic longint sine_sample(longint k);
    longint q, r, v;
    k = k % 1024;
    q = k / 256;
    r = k % 256;
    v = q[0] ? quarter_sine[256 - r] : quarter_sine[r];
    return q >= 2 ? -v : v;
  endfunction

  // c(t) in Q30, t with 16 fraction bits
  function automatic longint cycloid_q30(longint t);
    longint pos, a, b, s;
    pos = t * 1024;
    a = sine_sample(pos >> 16);
    b = sine_sample((pos >> 16) + 1);
    s = a + ((b - a) * (pos & 65535)) / 65536;
    return (t << 14) - (s * 170891319) / 65536;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] swing_side(longint t);
    longint m;
    m = 2 * cycloid_q30(t) - (t << 14) - (64'sd1 << 29);
    return clamp32((sx(stroke_q) * m) / (64'sd1 << 30) - sx(offset_q));
  endfunction

  function automatic logic [31:0] swing_vert(longint s);
    return clamp32(sx(base_q) - (sx(lift_q) * cycloid_q30(s)) / (64'sd1 << 30));
  endfunction

  function automatic logic [31:0] stance_side(longint q);
    longint          v, term;
    longint unsigned mag, num, quo;
    v   = sx(speed_q);
    mag = v < 0 ? -v : v;
    num = ((mag * q) >> 16) * (64'(tick_q) * 2);
    if (tscale_q == 0) quo = num == 0 ? 0 : 64'h7FFF_FFFF;
    else quo = num / 64'(tscale_q);
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    term = v < 0 ? -longint'(quo) : longint'(quo);
    return clamp32(sx(stroke_q) / 2 - term - sx(offset_q));
  endfunction

  // Update the held coordinates for one phase word and queue them
  task automatic predict_coords(logic [16:0] p);
    longint ph, r;
    ph = p;
    if (ph <= 65536) begin
      if (pair_q == PAIR_FIRST) begin
        if (ph <= 32768) begin
          held_side_q = swing_side(2 * ph);
          held_vert_q = swing_vert(ph <= 16384 ? 4 * ph : 131072 - 4 * ph);
        end else begin
          held_side_q = stance_side(ph - 32768);
          held_vert_q = base_q;
        end
      end else if (pair_q == PAIR_SECOND) begin
        if (ph < 32768) begin
          held_side_q = stance_side(ph);
          held_vert_q = base_q;
        end else begin
          r = ph - 32768;
          held_side_q = swing_side(2 * r);
          held_vert_q = swing_vert(r <= 16384 ? 4 * r : 131072 - 4 * r);
        end
      end
    end
    coord_queue.push_back({held_side_q, held_vert_q});
  endtask

  // Register write; called at a falling edge with the block idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_LEG_PAIR:     pair_q   = val[1:0];
      CFG_SIDE_STROKE:  stroke_q = val;
      CFG_BASE_HEIGHT:  base_q   = val;
      CFG_LIFT_HEIGHT:  lift_q   = val;
      CFG_SIDE_OFFSET:  offset_q = val;
      CFG_STANCE_SPEED: speed_q  = val;
      CFG_TIME_SCALE:   tscale_q = val[30:0];
      CFG_TICK_PERIOD:  tick_q   = val[30:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (coord_queue.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [1:0] pair, logic [31:0] stroke, logic [31:0] base,
                           logic [31:0] lift, logic [31:0] offs, logic [31:0] speed,
                           logic [31:0] tscale, logic [31:0] tick);
    wait_idle();
    write_reg(CFG_LEG_PAIR, {30'd0, pair});
    write_reg(CFG_SIDE_STROKE, stroke);
    write_reg(CFG_BASE_HEIGHT, base);
    write_reg(CFG_LIFT_HEIGHT, lift);
    write_reg(CFG_SIDE_OFFSET, offs);
    write_reg(CFG_STANCE_SPEED, speed);
    write_reg(CFG_TIME_SCALE, tscale);
    write_reg(CFG_TICK_PERIOD, tick);
  endtask

  // Send one phase word; entered and left at a falling edge
  task automatic send_phase(logic [16:0] p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    phase_i    = p;
    do @(posedge clk_i); while (in_stall_o);
    predict_coords(p);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 20 << 16)))
                                      : -32'(int'($urandom_range(0, 20 << 16)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 32'd1;
      1: v = 32'h7FFF_FFFF;
      default: v = $urandom_range(1 << 12, 1 << 20);
    endcase
    return v;
  endfunction

  function automatic logic [16:0] rand_phase();
    case ($urandom_range(0, 15))
      0: return 17'($urandom_range(65537, 131071));
      1: return 17'd65536;
      2: return 17'($urandom_range(32766, 32770));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Receiver stall: random bursts, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (long_hold > 0 && !long_taken) begin
      out_stall_i <= 1'b1;
      hold_cycles <= long_hold - 1;
      long_taken  <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= $urandom_range(0, 17);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    logic [63:0] exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coord_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word side=%h vert=%h",
                                       side_coord_o, vert_coord_o);
      end else begin
        exp_w = coord_queue.pop_front();
        if (exp_w[63:32] !== side_coord_o || exp_w[31:0] !== vert_coord_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: side exp %h got %h, vert exp %h got %h",
                     exp_w[63:32], side_coord_o, exp_w[31:0], vert_coord_o);
        end
      end
    end
  end

  task automatic test_reset_values();
    send_phase(17'd0);
    send_phase(17'd20000);
    send_phase(17'd50000);
  endtask

  task automatic test_first_pair();
    logic [16:0] pts [10] = '{0, 1, 16384, 16385, 32768, 32769, 49152, 65535, 65536, 65537};
    write_all(PAIR_FIRST, 32'd3 << 16, 32'hFFF6_0000, 32'd2 << 16, 32'h0000_8000,
              32'hFFFE_0000, 32'd65536, 32'd1000);
    foreach (pts[i]) send_phase(pts[i]);
  endtask

  task automatic test_second_pair();
    logic [16:0] pts [8] = '{0, 32767, 32768, 49152, 49153, 65536, 131071, 40000};
    write_all(PAIR_SECOND, 32'hFFFB_0000, 32'd5 << 16, 32'hFFFF_0000, 32'd0,
              32'd7 << 16, 32'd3000, 32'd65536);
    foreach (pts[i]) send_phase(pts[i]);
  endtask

  task automatic test_hold_pairs();
    write_all(2'd0, 32'd1 << 16, 32'd1 << 16, 32'd1 << 16, 32'd1 << 16, 32'd1 << 16,
              32'd65536, 32'd65536);
    send_phase(17'd100);
    send_phase(17'd40000);
    wait_idle();
    write_reg(CFG_LEG_PAIR, 32'd3);
    send_phase(17'd10000);
  endtask

  task automatic test_saturation();
    write_all(PAIR_FIRST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
    send_phase(17'd8000);
    send_phase(17'd60000);
    write_all(PAIR_SECOND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_phase(17'd30000);
    send_phase(17'd50000);
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    long_hold = 300;
    for (int i = 0; i < 6; i++) send_phase(rand_phase());
  endtask

  task automatic test_random();
    for (int blk = 0; blk < 18; blk++) begin
      if (blk == 14) quiet = 1'b1;
      write_all($urandom_range(0, 7) == 0 ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(1, 2)),
                rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_scale(), rand_scale());
      for (int i = 0; i < 50; i++) send_phase(rand_phase());
    end
  endtask

  initial begin
    fill_sine_table();
    pair_q = PAIR_FIRST;
    {stroke_q, base_q, lift_q, offset_q, speed_q} = '0;
    tscale_q = 31'd65536;
    tick_q   = 31'd65536;
    held_side_q = '0;
    held_vert_q = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_first_pair();
    test_second_pair();
    test_hold_pairs();
    test_saturation();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && coord_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
